// ===== hdl/tcws_pkg.sv =====
// shared types and constants for the two-choice worker select block
package tcws_pkg;

  localparam int HASH_W     = 32;
  localparam int LOAD_W     = 32;
  localparam int WIDX_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int SEL_W      = 6;
  localparam int HASH_SHIFT = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 8;

  localparam logic [PADDR_W-3:0] REG_WORKER_COUNT = '0;

  localparam logic ACT_SELECT = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  typedef struct packed {
    logic cap_in;
    logic start_div;
    logic cap_cand;
    logic rd_second;
    logic cap_a;
    logic cap_win;
    logic wr_load;
    logic wr_inc;
    logic out_load;
  } tcws_cmd_t;

  typedef struct packed {
    logic is_write;
    logic count_zero;
    logic div_done;
    logic div_busy;
    logic out_free;
  } tcws_stat_t;

endpackage

// ===== hdl/tcws_ram.sv =====
// generic single-write, single-read ram with registered read data
module tcws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tcws_div.sv =====
// iterative restoring divider, one quotient bit per cycle, remainder only
module tcws_div #(
  parameter int DW = 32,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [VW-1:0] rem
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd;
  logic [VW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      trial;
  logic [VW-1:0]    rem_next;

  always_comb begin
    trial = {rem, dvd[DW-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = VW'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

// ===== hdl/tcws_dp.sv =====
// datapath: input capture, candidate dividers, load table and result register
module tcws_dp import tcws_pkg::*; #(
  parameter int MAX_WORKERS_P = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_action,
  input  logic [HASH_W-1:0]  in_hash,
  input  logic [WIDX_W-1:0]  in_widx,
  input  logic [LOAD_W-1:0]  in_lval,
  input  logic [COUNT_W-1:0] worker_count,
  input  tcws_cmd_t          cmd,
  output tcws_stat_t         stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_dropped,
  output logic [SEL_W-1:0]   out_sel
);

  localparam int IW = (MAX_WORKERS_P > 1) ? $clog2(MAX_WORKERS_P) : 1;

  logic               act_q;
  logic [HASH_W-1:0]  hash_q;
  logic [WIDX_W-1:0]  widx_q;
  logic [LOAD_W-1:0]  lval_q;
  logic [COUNT_W-1:0] n_q;
  logic [COUNT_W-1:0] n_capped;

  logic               busy_a, busy_b, done_a, done_b;
  logic [COUNT_W-1:0] rem_a, rem_b;

  logic [COUNT_W-1:0] cand_a, cand_b, win_q;
  logic [COUNT_W:0]   cand_sum;
  logic [COUNT_W-1:0] cand_b_next;
  logic [LOAD_W-1:0]  load_a, win_load;

  logic [31:0]        a_ext, b_ext, w_ext, i_ext;
  logic               widx_ok;
  logic               ram_we;
  logic [IW-1:0]      raddr, waddr;
  logic [LOAD_W-1:0]  wdata, rdata, rload;
  logic [MAX_WORKERS_P-1:0] vld;
  logic               rvld;

  // cap the worker count at the table size
  always_comb begin
    if (32'(worker_count) > MAX_WORKERS_P) begin
      n_capped = COUNT_W'(MAX_WORKERS_P);
    end else begin
      n_capped = worker_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      act_q  <= in_action;
      hash_q <= in_hash;
      widx_q <= in_widx;
      lval_q <= in_lval;
      n_q    <= n_capped;
    end
  end

  tcws_div #(.DW(HASH_W), .VW(COUNT_W)) u_div_first (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (hash_q),
    .divisor  (n_q),
    .busy     (busy_a),
    .done     (done_a),
    .rem      (rem_a)
  );

  tcws_div #(.DW(HASH_W), .VW(COUNT_W)) u_div_second (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (hash_q >> HASH_SHIFT),
    .divisor  (n_q - 1'b1),
    .busy     (busy_b),
    .done     (done_b),
    .rem      (rem_b)
  );

  // second candidate wraps once at most
  always_comb begin
    cand_sum = {1'b0, rem_a} + {1'b0, rem_b} + 1'b1;
    if (cand_sum >= {1'b0, n_q}) begin
      cand_b_next = COUNT_W'(cand_sum - {1'b0, n_q});
    end else begin
      cand_b_next = cand_sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_cand) begin
      cand_a <= rem_a;
      cand_b <= cand_b_next;
    end
    if (cmd.cap_a) begin
      load_a <= rload;
    end
    if (cmd.cap_win) begin
      if (n_q > COUNT_W'(1) && rload < load_a) begin
        win_q    <= cand_b;
        win_load <= rload;
      end else begin
        win_q    <= cand_a;
        win_load <= load_a;
      end
    end
  end

  assign a_ext   = 32'(cand_a);
  assign b_ext   = 32'(cand_b);
  assign w_ext   = 32'(win_q);
  assign i_ext   = 32'(widx_q);
  assign widx_ok = i_ext < MAX_WORKERS_P;

  assign raddr  = cmd.rd_second ? b_ext[IW-1:0] : a_ext[IW-1:0];
  assign ram_we = (cmd.wr_load && widx_ok) || cmd.wr_inc;
  assign waddr  = cmd.wr_load ? i_ext[IW-1:0] : w_ext[IW-1:0];
  assign wdata  = cmd.wr_load ? lval_q : win_load + 1'b1;

  tcws_ram #(.WIDTH(LOAD_W), .DEPTH(MAX_WORKERS_P)) u_load_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rvld <= vld[raddr];
  end

  assign rload = rvld ? rdata : '0;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_dropped <= (act_q == ACT_SELECT) && (n_q == '0);
      if (act_q == ACT_WRITE || n_q == '0) begin
        out_sel <= '0;
      end else begin
        out_sel <= win_q[SEL_W-1:0];
      end
    end
  end

  assign stat.is_write   = act_q == ACT_WRITE;
  assign stat.count_zero = n_q == '0;
  assign stat.div_done   = done_a & done_b;
  assign stat.div_busy   = busy_a | busy_b;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== hdl/tcws_ctrl.sv =====
// controller: sequences decode, division, table reads, update and result
module tcws_ctrl import tcws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  tcws_stat_t stat,
  output tcws_cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE, DECODE, DIV, CAND, RDA, RDB, CMP, INC, WR, FIN
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready   = 1'b1;
        cmd.cap_in = in_valid;
        if (in_valid) begin
          state_next = DECODE;
        end
      end
      DECODE: begin
        if (stat.is_write) begin
          state_next = WR;
        end else if (stat.count_zero) begin
          state_next = FIN;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = DIV;
        end
      end
      DIV: begin
        if (stat.div_done) begin
          state_next = CAND;
        end
      end
      CAND: begin
        cmd.cap_cand = 1'b1;
        state_next   = RDA;
      end
      RDA: begin
        state_next = RDB;
      end
      RDB: begin
        cmd.rd_second = 1'b1;
        cmd.cap_a     = 1'b1;
        state_next    = CMP;
      end
      CMP: begin
        cmd.cap_win = 1'b1;
        state_next  = INC;
      end
      INC: begin
        cmd.wr_inc = 1'b1;
        state_next = FIN;
      end
      WR: begin
        cmd.wr_load = 1'b1;
        state_next  = FIN;
      end
      FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/two_choice_worker_select_top.sv =====
// top level of the two-choice worker select block with apb register port
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tuser: action; s_tdata: hash, index, load
//  m_*      out  m_tvalid / m_tready    m_tuser: dropped; m_tdata: selected_worker
//  apb      in   psel, penable, pready  worker_count at byte address 0
//
// a select beat runs the two remainder units in parallel over the 32-bit hash
// a load write beat goes from decode to the table write, a dropped connection from decode to the result
// reset clears the per-entry valid bits at once, so no clearing pass is needed
// one beat is worked at a time; a finished result waits in the output register
// and the next input beat is taken once that result has been moved into it
module two_choice_worker_select_top import tcws_pkg::*; #(
  parameter int MAX_WORKERS_P = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // flow_hash, worker_index, load_value
  input  logic [0:0]           s_tuser,  // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // selected_worker
  output logic [0:0]           m_tuser,  // dropped
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  logic [COUNT_W-1:0] worker_count;
  logic               cfg_wr;
  tcws_cmd_t          cmd;
  tcws_stat_t         stat;
  logic               out_dropped;
  logic [SEL_W-1:0]   out_sel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1:2] == REG_WORKER_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= '0;
    end else if (cfg_wr) begin
      worker_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_WORKER_COUNT: prdata = PDATA_W'(worker_count);
      default:          prdata = '0;
    endcase
  end

  tcws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcws_dp #(.MAX_WORKERS_P(MAX_WORKERS_P)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_action    (s_tuser[0]),
    .in_hash      (s_tdata[HASH_W-1:0]),
    .in_widx      (s_tdata[HASH_W+WIDX_W-1:HASH_W]),
    .in_lval      (s_tdata[HASH_W+WIDX_W+LOAD_W-1:HASH_W+WIDX_W]),
    .worker_count (worker_count),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_dropped  (out_dropped),
    .out_sel      (out_sel)
  );

  assign m_tdata = M_TDATA_W'(out_sel);
  assign m_tuser = out_dropped;

  a_drop_zero_sel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("dropped result carries a nonzero worker");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> !s_tready)
    else $error("input ready while remainder units run");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken before the first was worked");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> worker_count == $past(pwdata[COUNT_W-1:0]))
    else $error("worker count not updated by register write");

endmodule

// ===== verif/tb_two_choice_worker_select_top.sv =====
// self-checking testbench for the two-choice worker select block
`timescale 1ns / 100ps

module tb_two_choice_worker_select_top;
  import tcws_pkg::*;

  localparam int NUM_SLOTS   = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_BEATS = 100;
  localparam bit KNOWN       = 1'b1;
  localparam bit PREDICTED   = 1'b0;

  typedef struct packed {
    logic              dropped;
    logic [SEL_W-1:0]  worker;
  } pick_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic               act;
    logic [HASH_W-1:0]  hash;
    logic [WIDX_W-1:0]  idx;
    logic [LOAD_W-1:0]  load;
    logic               typed;
    logic               drop;
    logic [SEL_W-1:0]   sel;
  } probe_row_t;

  // worker count, action, hash, index, load, typed, dropped, worker
  localparam probe_row_t PROBE_ROWS [22] = '{
    '{7'd0,   ACT_SELECT, 32'h0000_0000, 6'd0,  32'h0000_0000, KNOWN,     1'b1, 6'd0},
    '{7'd0,   ACT_SELECT, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, KNOWN,     1'b1, 6'd0},
    '{7'd0,   ACT_WRITE,  32'h0000_0000, 6'd63, 32'hFFFF_FFFF, KNOWN,     1'b0, 6'd0},
    '{7'd0,   ACT_WRITE,  32'hFFFF_FFFF, 6'd0,  32'h0000_0000, KNOWN,     1'b0, 6'd0},
    '{7'd1,   ACT_SELECT, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000, KNOWN,     1'b0, 6'd0},
    '{7'd1,   ACT_SELECT, 32'h0000_0000, 6'd0,  32'h0000_0000, KNOWN,     1'b0, 6'd0},
    '{7'd1,   ACT_WRITE,  32'h0000_0000, 6'd1,  32'h0000_0000, KNOWN,     1'b0, 6'd0},
    '{7'd64,  ACT_SELECT, 32'h0000_0000, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd64,  ACT_WRITE,  32'h0000_0000, 6'd10, 32'hFFFF_FFFF, KNOWN,     1'b0, 6'd0},
    '{7'd64,  ACT_WRITE,  32'h0000_0000, 6'd11, 32'hFFFF_FFFF, KNOWN,     1'b0, 6'd0},
    '{7'd64,  ACT_SELECT, 32'h0000_000A, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd64,  ACT_SELECT, 32'h0000_000A, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd64,  ACT_SELECT, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd64,  ACT_SELECT, 32'h003E_003F, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd127, ACT_SELECT, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd127, ACT_SELECT, 32'h7FFF_FF80, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd127, ACT_WRITE,  32'h0000_0000, 6'd63, 32'h0000_0000, KNOWN,     1'b0, 6'd0},
    '{7'd2,   ACT_SELECT, 32'h0000_0001, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd2,   ACT_SELECT, 32'hFFFF_0000, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd65,  ACT_SELECT, 32'h1234_5678, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0},
    '{7'd65,  ACT_WRITE,  32'h0000_0000, 6'd32, 32'h8000_0000, KNOWN,     1'b0, 6'd0},
    '{7'd3,   ACT_SELECT, 32'hAAAA_5555, 6'd0,  32'h0000_0000, PREDICTED, 1'b0, 6'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  logic [LOAD_W-1:0]    worker_load [NUM_SLOTS];
  logic [COUNT_W-1:0]   active_workers = '0;
  pick_t                pending_picks [$];
  pick_t                head_pick;
  int                   mismatch_cnt = 0;
  int                   stall_cycles = 0;
  bit                   calm = 1'b0;

  two_choice_worker_select_top #(.MAX_WORKERS_P(NUM_SLOTS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    foreach (worker_load[w]) worker_load[w] = '0;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // two candidates from the hash, the strictly lighter one wins, ties keep the first
  function automatic pick_t choose_worker(input logic act, input logic [HASH_W-1:0] hash,
                                          input logic [WIDX_W-1:0] idx,
                                          input logic [LOAD_W-1:0] load);
    pick_t       r;
    int unsigned n;
    int unsigned first;
    int unsigned second;
    r = '0;
    if (act == ACT_WRITE) begin
      if (idx < NUM_SLOTS) worker_load[idx] = load;
    end else if (active_workers == 0) begin
      r.dropped = 1'b1;
    end else begin
      n = (active_workers > NUM_SLOTS) ? NUM_SLOTS : active_workers;
      first = hash % n;
      if (n > 1) begin
        second = (first + 1 + ((hash >> HASH_SHIFT) % (n - 1))) % n;
        if (worker_load[second] < worker_load[first]) first = second;
      end
      worker_load[first] = worker_load[first] + 1'b1;
      r.worker = first[SEL_W-1:0];
    end
    return r;
  endfunction

  task automatic send_beat(input logic act, input logic [HASH_W-1:0] hash,
                           input logic [WIDX_W-1:0] idx, input logic [LOAD_W-1:0] load,
                           input bit typed, input pick_t typed_pick);
    pick_t predicted;
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, load, idx, hash};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = choose_worker(act, hash, idx, load);
    pending_picks.push_back(typed ? typed_pick : predicted);
  endtask

  // write the worker count once the block has drained, then read it back
  task automatic set_workers(input logic [COUNT_W-1:0] cnt);
    logic [PDATA_W-1:0] readback;
    s_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WORKER_COUNT, 2'b00};
    pwdata  <= {{(PDATA_W-COUNT_W){1'b0}}, cnt};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    active_workers = cnt;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {{(PDATA_W-COUNT_W){1'b0}}, cnt})
      flag_mismatch($sformatf("worker_count readback %0h, wrote %0h", readback, cnt));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_picks.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat tdata=%0h tuser=%0b", m_tdata, m_tuser));
      end else begin
        head_pick = pending_picks.pop_front();
        if (m_tuser[0] !== head_pick.dropped)
          flag_mismatch($sformatf("dropped %0b, expected %0b", m_tuser[0], head_pick.dropped));
        if (m_tdata !== {2'b00, head_pick.worker})
          flag_mismatch($sformatf("selected_worker %0d, expected %0d", m_tdata,
                                  head_pick.worker));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [COUNT_W-1:0] cnt;
    logic               act;
    logic [HASH_W-1:0]  hash;
    logic [WIDX_W-1:0]  idx;
    logic [LOAD_W-1:0]  load;
    int                 live;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (PROBE_ROWS[r]) begin
      if (PROBE_ROWS[r].cnt != active_workers) set_workers(PROBE_ROWS[r].cnt);
      send_beat(PROBE_ROWS[r].act, PROBE_ROWS[r].hash, PROBE_ROWS[r].idx, PROBE_ROWS[r].load,
                PROBE_ROWS[r].typed, '{dropped: PROBE_ROWS[r].drop, worker: PROBE_ROWS[r].sel});
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cnt = 7'd2;
        1: cnt = 7'd64;
        2: cnt = COUNT_W'($urandom_range(3, 63));
        3: cnt = 7'd127;
        4: cnt = 7'd1;
        5: cnt = COUNT_W'($urandom_range(65, 126));
        6: cnt = 7'd0;
        default: cnt = COUNT_W'($urandom_range(0, 127));
      endcase
      set_workers(cnt);
      calm = (ph == 2);
      live = (cnt > NUM_SLOTS) ? NUM_SLOTS : cnt;
      for (int k = 0; k < PHASE_BEATS; k++) begin
        // hold off the sender until the block has caught up
        if (ph == 4 && k == PHASE_BEATS / 2) begin
          s_tvalid <= 1'b0;
          while (pending_picks.size() != 0) @(posedge clk);
        end
        act = ($urandom_range(99) < 25) ? ACT_WRITE : ACT_SELECT;
        case ($urandom_range(9))
          0: hash = '0;
          1: hash = '1;
          default: hash = $urandom;
        endcase
        idx = WIDX_W'((live > 0 && $urandom_range(1) == 1) ? $urandom_range(live - 1)
                                                           : $urandom_range(NUM_SLOTS - 1));
        case ($urandom_range(3))
          0: load = $urandom_range(3);
          1: load = 32'hFFFF_FFFF - $urandom_range(2);
          default: load = $urandom;
        endcase
        send_beat(act, hash, idx, load, PREDICTED, '0);
      end
      calm = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
